// ----- rtl/core/nfcdf_pkg.sv -----
// ----------------------------------------------------------------------------
// nfcdf_pkg
// Types, codes and constants shared by the normal-frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcdf_pkg;

   // default frame overhead added to the length byte
   localparam int unsigned FRAME_OVERHEAD = 8;

   // reset value of the buffer capacity register
   localparam logic [7:0] CAPACITY_RESET = 8'hFF;

   // stream byte values
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_TFI  = 8'hD5;

   // seed of the data checksum
   localparam logic [7:0] SUM_SEED = 8'hD5;

   // total size of an ack or nack frame
   localparam logic [8:0] ACK_FRAME_BYTES = 9'd6;

   // result status codes
   localparam logic [2:0] ST_BUSY      = 3'd0;
   localparam logic [2:0] ST_SUCCESS   = 3'd1;
   localparam logic [2:0] ST_ACK       = 3'd2;
   localparam logic [2:0] ST_NACK      = 3'd3;
   localparam logic [2:0] ST_TOO_SMALL = 3'd4;
   localparam logic [2:0] ST_LEN_CSUM  = 3'd5;
   localparam logic [2:0] ST_DATA_CSUM = 3'd6;
   localparam logic [2:0] ST_BAD_TFI   = 3'd7;

   // parser phase, one-hot
   typedef enum logic [7:0] {
      PH_START1  = 8'b0000_0001,
      PH_START2  = 8'b0000_0010,
      PH_LEN     = 8'b0000_0100,
      PH_LCS     = 8'b0000_1000,
      PH_TFI     = 8'b0001_0000,
      PH_DATA    = 8'b0010_0000,
      PH_POST    = 8'b0100_0000,
      PH_ACKPOST = 8'b1000_0000
   } phase_type;

   // parser state carried between bytes
   typedef struct packed {
      phase_type  phase;
      logic [7:0] remaining_length;
      logic [7:0] data_sum;
      logic [8:0] stored_count;
      logic [8:0] frame_size;
      logic       pending_nack;
   } parse_state_type;

   // one result item
   typedef struct packed {
      logic [2:0] status;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [8:0] frame_bytes;
   } result_type;

   // state after reset and after every terminal outcome
   localparam parse_state_type HUNT_STATE = '{
      phase:            PH_START1,
      remaining_length: 8'h00,
      data_sum:         SUM_SEED,
      stored_count:     9'd0,
      frame_size:       9'd0,
      pending_nack:     1'b0
   };

endpackage

`default_nettype wire

// ----- rtl/core/nfcdf_step.sv -----
// ----------------------------------------------------------------------------
// nfcdf_step
// Per-byte parser update: next state and the result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcdf_step #(
   parameter int unsigned FRAME_OVERHEAD = nfcdf_pkg::FRAME_OVERHEAD
) (
   input  wire logic [7:0]                 rx_byte,
   input  wire logic [7:0]                 capacity,
   input  wire nfcdf_pkg::parse_state_type cur_state,
   output nfcdf_pkg::parse_state_type      nxt_state,
   output nfcdf_pkg::result_type           result
);

   localparam logic [8:0] OVERHEAD = 9'(FRAME_OVERHEAD);

   nfcdf_pkg::parse_state_type st;
   nfcdf_pkg::result_type      res_pre;
   logic [2:0] status;
   logic [2:0] status_final;
   logic [8:0] len_total;
   logic [7:0] len_check;
   logic [7:0] sum_next;

   assign len_total = {1'b0, rx_byte} + OVERHEAD;
   assign len_check = rx_byte + cur_state.remaining_length;
   assign sum_next  = cur_state.data_sum + rx_byte;

   // phase update
   always_comb begin
      st                  = cur_state;
      st.stored_count     = cur_state.stored_count + 9'd1;
      status              = nfcdf_pkg::ST_BUSY;
      res_pre.data_valid  = 1'b0;
      res_pre.data_byte   = 8'h00;
      res_pre.frame_bytes = 9'd0;
      case (cur_state.phase)
         nfcdf_pkg::PH_START1: begin
            if (rx_byte == nfcdf_pkg::BYTE_ZERO) begin
               st.phase = nfcdf_pkg::PH_START2;
            end else begin
               st.stored_count = 9'd0;
            end
         end
         nfcdf_pkg::PH_START2: begin
            if (rx_byte == nfcdf_pkg::BYTE_FF) begin
               st.phase = nfcdf_pkg::PH_LEN;
            end else if (rx_byte == nfcdf_pkg::BYTE_ZERO) begin
               st.stored_count = 9'd1;
            end else begin
               st.phase        = nfcdf_pkg::PH_START1;
               st.stored_count = 9'd0;
            end
         end
         nfcdf_pkg::PH_LEN: begin
            st.remaining_length = rx_byte;
            if (len_total > {1'b0, capacity}) begin
               status = nfcdf_pkg::ST_TOO_SMALL;
            end else begin
               st.frame_size = len_total;
               st.phase      = nfcdf_pkg::PH_LCS;
            end
         end
         nfcdf_pkg::PH_LCS: begin
            if (rx_byte == nfcdf_pkg::BYTE_FF &&
                cur_state.remaining_length == nfcdf_pkg::BYTE_ZERO) begin
               st.pending_nack = 1'b0;
               st.frame_size   = nfcdf_pkg::ACK_FRAME_BYTES;
               st.phase        = nfcdf_pkg::PH_ACKPOST;
            end else if (rx_byte == nfcdf_pkg::BYTE_ZERO &&
                         cur_state.remaining_length == nfcdf_pkg::BYTE_FF) begin
               st.pending_nack = 1'b1;
               st.frame_size   = nfcdf_pkg::ACK_FRAME_BYTES;
               st.phase        = nfcdf_pkg::PH_ACKPOST;
            end else if (len_check != 8'h00) begin
               status = nfcdf_pkg::ST_LEN_CSUM;
            end else begin
               st.phase = nfcdf_pkg::PH_TFI;
            end
         end
         nfcdf_pkg::PH_TFI: begin
            if (rx_byte != nfcdf_pkg::BYTE_TFI) begin
               status = nfcdf_pkg::ST_BAD_TFI;
            end else begin
               // zero length wraps to 255 here
               st.remaining_length = cur_state.remaining_length - 8'd1;
               st.phase            = nfcdf_pkg::PH_DATA;
            end
         end
         nfcdf_pkg::PH_DATA: begin
            if (cur_state.remaining_length != 8'h00) begin
               st.data_sum         = sum_next;
               st.remaining_length = cur_state.remaining_length - 8'd1;
               res_pre.data_valid  = 1'b1;
               res_pre.data_byte   = rx_byte;
            end else if (sum_next != 8'h00) begin
               status = nfcdf_pkg::ST_DATA_CSUM;
            end else begin
               st.phase = nfcdf_pkg::PH_POST;
            end
         end
         nfcdf_pkg::PH_POST: begin
            status              = nfcdf_pkg::ST_SUCCESS;
            res_pre.frame_bytes = cur_state.frame_size;
         end
         nfcdf_pkg::PH_ACKPOST: begin
            status = cur_state.pending_nack ? nfcdf_pkg::ST_NACK : nfcdf_pkg::ST_ACK;
            res_pre.frame_bytes = nfcdf_pkg::ACK_FRAME_BYTES;
         end
         default: begin
            st.phase        = nfcdf_pkg::PH_START1;
            st.stored_count = 9'd0;
         end
      endcase
      res_pre.status = status;
   end

   // stored count limit and return to hunt on any terminal outcome
   always_comb begin
      status_final = status;
      if (status == nfcdf_pkg::ST_BUSY && st.stored_count > {1'b0, capacity}) begin
         status_final = nfcdf_pkg::ST_TOO_SMALL;
      end
      result        = res_pre;
      result.status = status_final;
      if (status_final != nfcdf_pkg::ST_BUSY) begin
         nxt_state = nfcdf_pkg::HUNT_STATE;
      end else begin
         nxt_state = st;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/nfc_normal_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// nfc_normal_frame_deframer_unit
// Normal-frame deframer for the host link of a contactless reader chip.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per request (req_valid / req_stall).
//   rsp_* returns exactly one result per request: status, payload byte
//   with its valid flag, and total frame size on ack, nack or success.
//   csr_write_enable / csr_write_data set the buffer capacity; write it
//   only while no request is in flight.
// Pipeline and throughput:
//   a request is held in an input register, then the parser update runs
//   in one pass into the result register. One request per cycle is
//   sustained while rsp_stall is low; the parser state register is the
//   only loop.
// Reset:
//   the parser returns to the start-code hunt, the capacity goes to 255
//   and both pipeline registers are emptied.
// Stall:
//   while rsp_stall holds a waiting result, the input register still takes
//   a request if it is empty; req_stall rises once both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_normal_frame_deframer_unit #(
   parameter int unsigned FRAME_OVERHEAD = nfcdf_pkg::FRAME_OVERHEAD
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_status,
   output logic            rsp_data_valid,
   output logic [7:0]      rsp_data_byte,
   output logic [8:0]      rsp_frame_bytes,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   nfcdf_pkg::result_type      out_result_ff;
   nfcdf_pkg::parse_state_type state_ff;
   nfcdf_pkg::parse_state_type state_next;
   nfcdf_pkg::result_type      step_result;
   logic [7:0]                 capacity_ff;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   // handshake control
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // per-byte parser update
   nfcdf_step #(
      .FRAME_OVERHEAD(FRAME_OVERHEAD)
   ) u_step (
      .rx_byte  (in_byte_ff),
      .capacity (capacity_ff),
      .cur_state(state_ff),
      .nxt_state(state_next),
      .result   (step_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= nfcdf_pkg::HUNT_STATE;
         capacity_ff  <= nfcdf_pkg::CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_result_ff.status;
   assign rsp_data_valid  = out_result_ff.data_valid;
   assign rsp_data_byte   = out_result_ff.data_byte;
   assign rsp_frame_bytes = out_result_ff.frame_bytes;

endmodule

`default_nettype wire

// ----- dv/tb_nfc_normal_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_nfc_normal_frame_deframer_unit
// Self-checking testbench for the normal-frame deframer. Streams received
// bytes into the block: a short directed opening, then random frames (good,
// ack, nack, zero length, noise, with random corruption) under several buffer
// capacities. A scoreboard tracks the parser state, predicts one result per
// accepted request and checks every result field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nfc_normal_frame_deframer_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BYTES  = 220;
   localparam int CALM_AFTER   = 1200;
   localparam int PRINT_LIMIT  = 50;

   // scoreboard: parser state copy, expected results, field checks
   class frame_scoreboard;
      nfcdf_pkg::parse_state_type st;
      logic [7:0]                 capacity;
      nfcdf_pkg::result_type      expected_q[$];
      int                         mismatches;
      int                         matched;
      int                         status_seen[8];

      function new();
         st = nfcdf_pkg::HUNT_STATE;
         capacity = nfcdf_pkg::CAPACITY_RESET;
         mismatches = 0;
         matched = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_capacity(logic [7:0] value);
         capacity = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // advance the parser by one byte and return its result
      function nfcdf_pkg::result_type parse_byte(logic [7:0] b);
         nfcdf_pkg::result_type r;
         logic [7:0]            sum8;
         int unsigned           total;
         r = '0;
         r.status = nfcdf_pkg::ST_BUSY;
         st.stored_count = st.stored_count + 9'd1;
         case (st.phase)
            nfcdf_pkg::PH_START1: begin
               if (b == nfcdf_pkg::BYTE_ZERO) st.phase = nfcdf_pkg::PH_START2;
               else st.stored_count = 9'd0;
            end
            nfcdf_pkg::PH_START2: begin
               if (b == nfcdf_pkg::BYTE_FF) begin
                  st.phase = nfcdf_pkg::PH_LEN;
               end else if (b == nfcdf_pkg::BYTE_ZERO) begin
                  st.stored_count = 9'd1;
               end else begin
                  st.phase = nfcdf_pkg::PH_START1;
                  st.stored_count = 9'd0;
               end
            end
            nfcdf_pkg::PH_LEN: begin
               st.remaining_length = b;
               total = b + nfcdf_pkg::FRAME_OVERHEAD;
               if (total > capacity) begin
                  r.status = nfcdf_pkg::ST_TOO_SMALL;
               end else begin
                  st.frame_size = total[8:0];
                  st.phase = nfcdf_pkg::PH_LCS;
               end
            end
            nfcdf_pkg::PH_LCS: begin
               sum8 = b + st.remaining_length;
               if (b == nfcdf_pkg::BYTE_FF && st.remaining_length == 8'h00) begin
                  st.pending_nack = 1'b0;
                  st.frame_size = nfcdf_pkg::ACK_FRAME_BYTES;
                  st.phase = nfcdf_pkg::PH_ACKPOST;
               end else if (b == nfcdf_pkg::BYTE_ZERO && st.remaining_length == 8'hFF) begin
                  st.pending_nack = 1'b1;
                  st.frame_size = nfcdf_pkg::ACK_FRAME_BYTES;
                  st.phase = nfcdf_pkg::PH_ACKPOST;
               end else if (sum8 != 8'h00) begin
                  r.status = nfcdf_pkg::ST_LEN_CSUM;
               end else begin
                  st.phase = nfcdf_pkg::PH_TFI;
               end
            end
            nfcdf_pkg::PH_TFI: begin
               if (b != nfcdf_pkg::BYTE_TFI) begin
                  r.status = nfcdf_pkg::ST_BAD_TFI;
               end else begin
                  st.remaining_length = st.remaining_length - 8'd1;
                  st.phase = nfcdf_pkg::PH_DATA;
               end
            end
            nfcdf_pkg::PH_DATA: begin
               if (st.remaining_length != 8'h00) begin
                  st.data_sum = st.data_sum + b;
                  st.remaining_length = st.remaining_length - 8'd1;
                  r.data_valid = 1'b1;
                  r.data_byte = b;
               end else begin
                  sum8 = st.data_sum + b;
                  if (sum8 != 8'h00) r.status = nfcdf_pkg::ST_DATA_CSUM;
                  else st.phase = nfcdf_pkg::PH_POST;
               end
            end
            nfcdf_pkg::PH_POST: begin
               r.status = nfcdf_pkg::ST_SUCCESS;
               r.frame_bytes = st.frame_size;
            end
            nfcdf_pkg::PH_ACKPOST: begin
               r.status = st.pending_nack ? nfcdf_pkg::ST_NACK : nfcdf_pkg::ST_ACK;
               r.frame_bytes = nfcdf_pkg::ACK_FRAME_BYTES;
            end
            default: begin
               st.phase = nfcdf_pkg::PH_START1;
               st.stored_count = 9'd0;
            end
         endcase
         // stored count limit is a strict test, one byte past capacity
         if (r.status == nfcdf_pkg::ST_BUSY && st.stored_count > {1'b0, capacity})
            r.status = nfcdf_pkg::ST_TOO_SMALL;
         if (r.status != nfcdf_pkg::ST_BUSY)
            st = nfcdf_pkg::HUNT_STATE;
         return r;
      endfunction

      function void note_request(logic [7:0] b);
         nfcdf_pkg::result_type r;
         r = parse_byte(b);
         expected_q.push_back(r);
         status_seen[r.status]++;
      endfunction

      // one line per mismatch, printing capped to keep the log short
      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_result(nfcdf_pkg::result_type got);
         nfcdf_pkg::result_type want;
         if (expected_q.size() == 0) begin
            report("result with no request waiting");
            return;
         end
         want = expected_q.pop_front();
         if (got.status != want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             matched, got.status, want.status));
         if (got.data_valid != want.data_valid)
            report($sformatf("result %0d data_valid %0d, expected %0d",
                             matched, got.data_valid, want.data_valid));
         if (got.data_byte != want.data_byte)
            report($sformatf("result %0d data_byte %02h, expected %02h",
                             matched, got.data_byte, want.data_byte));
         if (got.frame_bytes != want.frame_bytes)
            report($sformatf("result %0d frame_bytes %0d, expected %0d",
                             matched, got.frame_bytes, want.frame_bytes));
         matched++;
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic [8:0] rsp_frame_bytes;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   frame_scoreboard sb;
   int  total_sent = 0;
   int  settings_used = 0;
   int  cycles = 0;
   bit  calm = 1'b0;

   nfc_normal_frame_deframer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_bytes  (rsp_frame_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always #CLOCK_HALF clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_status, rsp_data_valid, rsp_data_byte, rsp_frame_bytes});
   end

   // receiver stall bursts, none once the run goes calm
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // drive one request and wait for it to be taken; returns at a falling edge
   task automatic send_byte(logic [7:0] b);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(b);
      total_sent++;
      if (total_sent >= CALM_AFTER) calm = 1'b1;
      @(negedge clock);
   endtask

   // stop sending and wait until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(logic [7:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_capacity(value);
      settings_used++;
   endtask

   // one random frame, or a short burst of noise
   task automatic send_frame();
      logic [7:0] q[$];
      logic [7:0] len;
      logic [7:0] sum8;
      logic [7:0] b;
      int         kind;
      int         n;
      int         spot;
      kind = $urandom_range(0, 99);
      // stray zero ahead of the start code
      if ($urandom_range(0, 9) == 0) q.push_back(nfcdf_pkg::BYTE_ZERO);
      if (kind < 55) begin
         if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(1, 255));
         else len = 8'($urandom_range(1, 12));
         sum8 = 8'h00 - len;
         q.push_back(nfcdf_pkg::BYTE_ZERO);
         q.push_back(nfcdf_pkg::BYTE_FF);
         q.push_back(len);
         q.push_back(sum8);
         q.push_back(nfcdf_pkg::BYTE_TFI);
         sum8 = nfcdf_pkg::SUM_SEED;
         for (int i = 1; i < len; i++) begin
            b = 8'($urandom);
            sum8 = sum8 + b;
            q.push_back(b);
         end
         q.push_back(8'h00 - sum8);
         q.push_back(8'($urandom));
      end else if (kind < 70) begin
         q = {q, nfcdf_pkg::BYTE_ZERO, nfcdf_pkg::BYTE_FF, nfcdf_pkg::BYTE_ZERO,
              nfcdf_pkg::BYTE_FF, 8'($urandom)};
      end else if (kind < 75) begin
         q = {q, nfcdf_pkg::BYTE_ZERO, nfcdf_pkg::BYTE_FF, nfcdf_pkg::BYTE_FF,
              nfcdf_pkg::BYTE_ZERO, 8'($urandom)};
      end else if (kind < 80) begin
         // zero length: payload runs until the stored count limit
         q = {q, nfcdf_pkg::BYTE_ZERO, nfcdf_pkg::BYTE_FF, nfcdf_pkg::BYTE_ZERO,
              nfcdf_pkg::BYTE_ZERO, nfcdf_pkg::BYTE_TFI};
         n = int'(sb.capacity) + 4;
         repeat (n) q.push_back(8'($urandom));
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0, 1:    q.push_back(nfcdf_pkg::BYTE_ZERO);
               2:       q.push_back(nfcdf_pkg::BYTE_FF);
               default: q.push_back(8'($urandom));
            endcase
         end
      end
      // occasionally corrupt one byte of a frame
      if (kind < 75 && $urandom_range(0, 4) == 0) begin
         spot = $urandom_range(0, q.size() - 1);
         q[spot] = 8'($urandom);
      end
      foreach (q[i]) send_byte(q[i]);
   endtask

   // main sequence
   initial begin
      logic [7:0] opening_q[$];
      logic [7:0] settings_q[$];
      int         phase_start;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data = 8'h00;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening at full capacity
      write_capacity(nfcdf_pkg::CAPACITY_RESET);
      opening_q = {
         8'h5A,                                           // noise while hunting
         8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h3C,        // repeated zero, then ack
         8'h00, 8'hFF, 8'hFF,                             // nack length, too large
         8'h00, 8'hFF, 8'h03, 8'hFD, 8'hD5, 8'h00, 8'hFF, // good frame, data 00 ff
         8'h2C, 8'hFF,
         8'h00, 8'hFF, 8'h02, 8'h00,                      // bad length checksum
         8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00                // bad identifier
      };
      foreach (opening_q[i]) send_byte(opening_q[i]);

      // random frames under a sweep of capacities
      settings_q = {8'd8, 8'd0, 8'd9, 8'($urandom_range(10, 254)), 8'd20, 8'd255};
      foreach (settings_q[i]) begin
         write_capacity(settings_q[i]);
         phase_start = total_sent;
         while (total_sent - phase_start < PHASE_BYTES) send_frame();
      end

      // wait out the pipeline, then close
      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));
      $display("sent %0d requests under %0d capacity settings, %0d results checked",
               total_sent, settings_used, sb.matched);
      $display({"outcomes: ok %0d, ack %0d, nack %0d, too small %0d, ",
                "len csum %0d, data csum %0d, bad id %0d"},
               sb.status_seen[nfcdf_pkg::ST_SUCCESS], sb.status_seen[nfcdf_pkg::ST_ACK],
               sb.status_seen[nfcdf_pkg::ST_NACK], sb.status_seen[nfcdf_pkg::ST_TOO_SMALL],
               sb.status_seen[nfcdf_pkg::ST_LEN_CSUM],
               sb.status_seen[nfcdf_pkg::ST_DATA_CSUM],
               sb.status_seen[nfcdf_pkg::ST_BAD_TFI]);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
